// File: design/rhr_pkg.sv
package rhr_pkg;

  // Ring geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int CAP_W   = 7;
  localparam int OP_W    = 2;
  localparam int ACT_W   = 2;
  localparam int FRAME_W = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
  localparam logic [OP_W-1:0] OP_REWIND  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the input beat
    logic prep;    // apply trim and cursor pre-update
    logic finish;  // commit result and state
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } dp_stat_t;

  // Physical slot of a logical position: (base + ofs) mod DEPTH, ofs <= DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

// File: design/rhr_ram.sv
module rhr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rhr_ctrl.sv
module rhr_ctrl import rhr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: accept, prepare, read store, execute
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the new beat
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/rhr_dp.sv
module rhr_dp import rhr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic [OP_W-1:0]    operation,
  input  logic [FRAME_W-1:0] frame_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic [ACT_W-1:0]   action,
  output logic [ADDR_W-1:0]  slot,
  output logic [CNT_W-1:0]   entry_count,
  output logic               is_empty,
  output logic [FRAME_W-1:0] cursor_frame
);

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Configuration and latched input
  logic [CAP_W-1:0]   capacity;
  logic [OP_W-1:0]    op_q;
  logic [FRAME_W-1:0] frame_q;

  // History state
  logic [ADDR_W-1:0] oldest;
  logic [CNT_W-1:0]  held;
  logic [ADDR_W-1:0] off;
  logic              at_newest;

  logic [CNT_W-1:0] cap_eff;

  // Trim and pre-operation values
  logic [CNT_W-1:0]  over;
  logic [ADDR_W-1:0] t_oldest;
  logic [CNT_W-1:0]  t_held;
  logic [ADDR_W-1:0] t_off;
  logic              t_new;
  logic [CNT_W-1:0]  off_inc;
  logic [CNT_W-1:0]  held_cut;
  logic [ADDR_W-1:0] p_oldest;
  logic [CNT_W-1:0]  p_held;
  logic [ADDR_W-1:0] p_off;
  logic              p_new;

  // Store access
  logic [CNT_W-1:0]   held_m1;
  logic [CNT_W-1:0]   rd_idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic [FRAME_W-1:0] rd_data;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CNT_W:0]     held_inc;

  // Execute values
  logic               e_we;
  logic               e_acc;
  logic [ACT_W-1:0]   e_act;
  logic [ADDR_W-1:0]  e_slot;
  logic [FRAME_W-1:0] e_cur;
  logic [ADDR_W-1:0]  e_oldest;
  logic [CNT_W-1:0]   e_held;
  logic [ADDR_W-1:0]  e_off;
  logic               e_new;

  // Capacity clamped to the ring depth
  always_comb begin
    if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // Trim to capacity, then cursor work that precedes the store read
  always_comb begin
    over     = held - cap_eff;
    t_oldest = oldest;
    t_held   = held;
    t_off    = off;
    t_new    = at_newest;
    if (cap_eff == '0) begin
      t_oldest = '0;
      t_held   = '0;
      t_off    = '0;
      t_new    = 1'b1;
    end else if (held > cap_eff) begin
      t_oldest = ring_add(oldest, over);
      t_held   = cap_eff;
      if (!at_newest) begin
        t_off = (CNT_W'(off) > over) ? ADDR_W'(CNT_W'(off) - over) : '0;
      end
    end

    off_inc  = CNT_W'(t_off) + CNT_W'(1);
    held_cut = (off_inc < t_held) ? off_inc : t_held;
    p_oldest = t_oldest;
    p_held   = t_held;
    p_off    = t_off;
    p_new    = t_new;
    case (op_q)
      OP_CAPTURE: begin
        // drop entries newer than a rewound cursor
        if (!t_new && t_held != '0) begin
          p_held = held_cut;
          p_new  = 1'b1;
          p_off  = ADDR_W'(held_cut - CNT_W'(1));
        end
      end
      OP_REWIND: begin
        if (t_held != '0) begin
          if (t_new) begin
            p_off = (t_held > CNT_W'(1)) ? ADDR_W'(t_held - CNT_W'(2)) : '0;
            p_new = 1'b0;
          end else if (t_off != '0) begin
            p_off = t_off - ADDR_W'(1);
          end
          if (CNT_W'(p_off) >= t_held) begin
            p_off = ADDR_W'(t_held - CNT_W'(1));
          end
        end
      end
      OP_CLEAR: begin
        p_oldest = '0;
        p_held   = '0;
        p_off    = '0;
        p_new    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Cursor entry address (newest entry when live)
  always_comb begin
    held_m1 = held - CNT_W'(1);
    if (at_newest || CNT_W'(off) >= held) begin
      rd_idx = held_m1;
    end else begin
      rd_idx = CNT_W'(off);
    end
    rd_addr  = ring_add(oldest, rd_idx);
    wr_addr  = ring_add(oldest, held);
    held_inc = (CNT_W+1)'(held) + (CNT_W+1)'(1);
  end

  rhr_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.finish && e_we),
    .waddr(wr_addr),
    .wdata(frame_q),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Result and final state from the store data
  always_comb begin
    e_we     = 1'b0;
    e_acc    = 1'b0;
    e_act    = ACT_NONE;
    e_slot   = '0;
    e_cur    = (held != '0) ? rd_data : '0;
    e_oldest = oldest;
    e_held   = held;
    e_off    = off;
    e_new    = at_newest;
    case (op_q)
      OP_CAPTURE: begin
        e_acc = 1'b1;
        if (held != '0 && rd_data == frame_q) begin
          // same frame as newest entry: rewrite in place
          e_act  = ACT_WRITE;
          e_slot = rd_addr;
          e_off  = ADDR_W'(held_m1);
          e_cur  = frame_q;
        end else begin
          e_we = 1'b1;
          if (cap_eff == '0) begin
            // appended and dropped at once
            e_oldest = '0;
            e_held   = '0;
            e_off    = '0;
            e_new    = 1'b1;
            e_cur    = '0;
          end else begin
            if (held_inc > (CNT_W+1)'(cap_eff)) begin
              e_oldest = ring_add(oldest, CNT_W'(1));
              e_held   = cap_eff;
            end else begin
              e_held = CNT_W'(held_inc);
            end
            e_new  = 1'b1;
            e_off  = ADDR_W'(e_held - CNT_W'(1));
            e_act  = ACT_WRITE;
            e_slot = wr_addr;
            e_cur  = frame_q;
          end
        end
      end
      OP_REWIND: begin
        if (held != '0) begin
          e_acc  = 1'b1;
          e_act  = ACT_LOAD;
          e_slot = rd_addr;
        end
      end
      OP_CLEAR: begin
        e_acc = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_W'(DEPTH);
      oldest    <= '0;
      held      <= '0;
      off       <= '0;
      at_newest <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.prep) begin
        oldest    <= p_oldest;
        held      <= p_held;
        off       <= p_off;
        at_newest <= p_new;
      end else if (cmd.finish) begin
        oldest    <= e_oldest;
        held      <= e_held;
        off       <= e_off;
        at_newest <= e_new;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      frame_q <= frame_number;
    end
    if (cmd.finish) begin
      accepted     <= e_acc;
      action       <= e_act;
      slot         <= e_slot;
      entry_count  <= e_held;
      is_empty     <= (e_held == '0);
      cursor_frame <= e_cur;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

// File: design/rewind_history_ring_unit.sv
// Each input beat steps through accept, trim, frame store read and execute;
// the result is registered at execute, which waits while the result
// register is not taken. A new beat is accepted only after execute.
// Reset (rst, synchronous): history empty, cursor live, capacity 64,
// no result pending. The frame store holds no reset value.
module rewind_history_ring_unit import rhr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [FRAME_W-1:0] frame_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic [ACT_W-1:0]   action,
  output logic [ADDR_W-1:0]  slot,
  output logic [CNT_W-1:0]   entry_count,
  output logic               is_empty,
  output logic [FRAME_W-1:0] cursor_frame
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rhr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rhr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .operation    (operation),
    .frame_number (frame_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .action       (action),
    .slot         (slot),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .cursor_frame (cursor_frame)
  );

endmodule

// File: verif/rewind_history_ring_unit_tb.sv
`timescale 1ns / 100ps

module rewind_history_ring_unit_tb import rhr_pkg::*;;

  // Operation code the block does not define; it must be ignored
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Capacity per random phase
  localparam int PHASE_CAP [8] = '{64, 3, 127, 12, 1, 64, 30, 100};

  // One result beat, field by field
  typedef struct packed {
    logic               accepted;
    logic [ACT_W-1:0]   action;
    logic [ADDR_W-1:0]  slot;
    logic [CNT_W-1:0]   entry_count;
    logic               is_empty;
    logic [FRAME_W-1:0] cursor_frame;
  } ring_report_t;

  // Mirror of the checkpoint history; predicts each result and checks it
  class rewind_history_mirror;
    logic [FRAME_W-1:0] frame_at [DEPTH];
    logic [ADDR_W-1:0]  oldest;
    logic [CNT_W-1:0]   held;
    logic [ADDR_W-1:0]  cursor;
    bit                 live;
    logic [CAP_W-1:0]   capacity;
    ring_report_t       expected_reports [$];
    int                 mismatch_count;

    function new();
      capacity = CAP_W'(DEPTH);
      mismatch_count = 0;
      empty_out();
    endfunction

    function void empty_out();
      held = '0;
      oldest = '0;
      cursor = '0;
      live = 1'b1;
    endfunction

    function logic [ADDR_W-1:0] ring_pos(int logical);
      return ADDR_W'((int'(oldest) + logical) % DEPTH);
    endfunction

    function void adopt_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction

    // Drop the oldest entries beyond capacity; a rewound cursor follows them
    function void drop_excess();
      int cap;
      int over;
      cap = (capacity > DEPTH) ? DEPTH : int'(capacity);
      if (cap == 0) begin
        empty_out();
        return;
      end
      if (held <= cap) return;
      over = held - cap;
      oldest = ring_pos(over);
      held = CNT_W'(cap);
      if (!live) cursor = (cursor > over) ? ADDR_W'(cursor - over) : '0;
    endfunction

    // Accepted input beat: advance the history and queue its result
    function void note_op(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frame);
      ring_report_t want;
      logic [ADDR_W-1:0] fresh;
      logic [CNT_W-1:0] pos;
      want = '0;
      drop_excess();
      case (op)
        OP_CAPTURE: begin
          want.accepted = 1'b1;
          // drop entries newer than a rewound cursor
          if (!live && held != 0) begin
            if (cursor + 1 < held) held = CNT_W'(cursor + 1);
            live = 1'b1;
            cursor = ADDR_W'(held - 1);
          end
          if (held != 0 && frame_at[ring_pos(held - 1)] == frame) begin
            // same frame as newest: rewrite in place
            want.action = ACT_WRITE;
            want.slot = ring_pos(held - 1);
            cursor = ADDR_W'(held - 1);
          end else begin
            fresh = ring_pos(held);
            frame_at[fresh] = frame;
            held = held + 1'b1;
            drop_excess();
            live = 1'b1;
            cursor = (held != 0) ? ADDR_W'(held - 1) : '0;
            if (held != 0) begin
              want.action = ACT_WRITE;
              want.slot = fresh;
            end
          end
        end
        OP_REWIND: begin
          if (held != 0) begin
            if (live) begin
              cursor = (held > 1) ? ADDR_W'(held - 2) : '0;
              live = 1'b0;
            end else if (cursor != 0) begin
              cursor = cursor - 1'b1;
            end
            if (cursor >= held) cursor = ADDR_W'(held - 1);
            want.accepted = 1'b1;
            want.action = ACT_LOAD;
            want.slot = ring_pos(cursor);
          end
        end
        OP_CLEAR: begin
          empty_out();
          want.accepted = 1'b1;
        end
        default: begin
        end
      endcase
      if (held != 0) begin
        pos = live ? CNT_W'(held - 1) : CNT_W'(cursor);
        if (pos >= held) pos = CNT_W'(held - 1);
        want.cursor_frame = frame_at[ring_pos(pos)];
      end
      want.entry_count = held;
      want.is_empty = (held == 0);
      expected_reports.insert(expected_reports.size(), want);
    endfunction

    // Accepted result beat: compare against the oldest prediction
    function void check_report(ring_report_t got);
      ring_report_t want;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: acc=%0b act=%0d slot=%0d cnt=%0d empty=%0b frame=%h",
                   got.accepted, got.action, got.slot, got.entry_count, got.is_empty,
                   got.cursor_frame);
        return;
      end
      want = expected_reports.pop_front();
      if (got.accepted !== want.accepted || got.action !== want.action ||
          got.slot !== want.slot || got.entry_count !== want.entry_count ||
          got.is_empty !== want.is_empty || got.cursor_frame !== want.cursor_frame) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch exp: acc=%0b act=%0d slot=%0d cnt=%0d empty=%0b frame=%h",
                   want.accepted, want.action, want.slot, want.entry_count, want.is_empty,
                   want.cursor_frame);
          $display("                got: acc=%0b act=%0d slot=%0d cnt=%0d empty=%0b frame=%h",
                   got.accepted, got.action, got.slot, got.entry_count, got.is_empty,
                   got.cursor_frame);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation = OP_CAPTURE;
  logic [FRAME_W-1:0] frame_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic [ACT_W-1:0]   action;
  logic [ADDR_W-1:0]  slot;
  logic [CNT_W-1:0]   entry_count;
  logic               is_empty;
  logic [FRAME_W-1:0] cursor_frame;

  rewind_history_mirror history = new();

  int                 sender_idle_pct = 38;
  int                 recv_idle_pct = 62;
  logic               hold_off_go = 1'b0;
  bit                 hold_done = 1'b0;
  int                 hold_left = 0;
  logic [FRAME_W-1:0] next_frame = '0;

  rewind_history_ring_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .frame_number  (frame_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .action        (action),
    .slot          (slot),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .cursor_frame  (cursor_frame)
  );

  always #6 clk = ~clk;

  // Result side: check each beat, then pick ready for the next cycle
  always @(posedge clk) begin : result_side
    ring_report_t seen;
    seen = {accepted, action, slot, entry_count, is_empty, cursor_frame};
    if (!rst && out_valid && out_ready) history.check_report(seen);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_go && !hold_done) begin
      // long hold-off so the block backs up into its input
      hold_left <= 100;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one input beat after a random gap; returns at the accepting edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    frame_number <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    history.note_op(op, frame);
  endtask

  // Capacity write once every result is back
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (history.outstanding() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    history.adopt_capacity(value);
  endtask

  // Mostly well-formed capture/rewind sequences, some clears and noise
  task automatic random_burst(input int budget);
    int sent;
    int kind;
    int run;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // run of fresh captures
        run = $urandom_range(1, 10);
        repeat (run) begin
          next_frame = next_frame + $urandom_range(1, 3);
          send_op(OP_CAPTURE, next_frame);
        end
      end else if (kind < 65) begin
        // step back, then capture; a nearby frame may match the new newest
        run = $urandom_range(1, 6);
        repeat (run) send_op(OP_REWIND, {$urandom, $urandom});
        send_op(OP_CAPTURE, next_frame - $urandom_range(0, 6));
        run++;
      end else if (kind < 78) begin
        // repeat of the last frame
        send_op(OP_CAPTURE, next_frame);
        run = 1;
      end else if (kind < 82) begin
        send_op(OP_CLEAR, {$urandom, $urandom});
        run = 1;
      end else begin
        // noise: any code, any frame
        send_op(OP_W'($urandom_range(OP_CAPTURE, OP_UNUSED)), {$urandom, $urandom});
        run = 1;
      end
      sent += run;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty history, rewrite, rewind to oldest, truncation
    send_op(OP_REWIND, '0);
    send_op(OP_UNUSED, '0);
    send_op(OP_CLEAR, '0);
    send_op(OP_CAPTURE, '0);
    send_op(OP_CAPTURE, '0);
    send_op(OP_CAPTURE, '1);
    send_op(OP_CAPTURE, 64'd5);
    send_op(OP_CAPTURE, 64'd6);
    repeat (5) send_op(OP_REWIND, '1);
    send_op(OP_CAPTURE, '0);
    send_op(OP_CAPTURE, 64'd9);
    send_op(OP_REWIND, '0);
    send_op(OP_CAPTURE, 64'd100);
    send_op(OP_UNUSED, '1);
    send_op(OP_CLEAR, '1);
    send_op(OP_CAPTURE, 64'd1);

    // capacity zero: capture is taken and dropped at once
    write_capacity('0);
    send_op(OP_CAPTURE, 64'd7);
    send_op(OP_REWIND, '0);
    send_op(OP_UNUSED, '0);

    // capacity two: eviction of the oldest
    write_capacity(CAP_W'(2));
    send_op(OP_CAPTURE, 64'd1);
    send_op(OP_CAPTURE, 64'd2);
    send_op(OP_CAPTURE, 64'd3);
    send_op(OP_REWIND, '0);
    send_op(OP_REWIND, '0);
    send_op(OP_CAPTURE, 64'd3);

    // full ring with wrap, then trims under a rewound cursor
    write_capacity('1);
    next_frame = 64'd1000;
    repeat (70) begin
      next_frame = next_frame + 1;
      send_op(OP_CAPTURE, next_frame);
    end
    repeat (3) send_op(OP_REWIND, '0);
    write_capacity(CAP_W'(40));
    send_op(OP_UNUSED, '0);
    write_capacity(CAP_W'(3));
    send_op(OP_REWIND, '0);
    send_op(OP_CAPTURE, next_frame);

    // random phases, capacity changed between them without clearing
    for (int p = 0; p < 8; p++) begin
      write_capacity(CAP_W'(PHASE_CAP[p]));
      if (p < 3) begin
        sender_idle_pct = 38;
        recv_idle_pct <= 62;
      end else if (p < 6) begin
        sender_idle_pct = 62;
        recv_idle_pct <= 38;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (p == 3) hold_off_go <= 1'b1;
      random_burst(35);
    end

    in_valid <= 1'b0;
    while (history.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (history.mismatch_count == 0 && history.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/rhr_pkg.sv
design/rhr_ram.sv
design/rhr_ctrl.sv
design/rhr_dp.sv
design/rewind_history_ring_unit.sv
verif/rewind_history_ring_unit_tb.sv
